// ----- rtl/mwno_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwno_pkg
// Shared types, codes and constants of the multi-waveform note oscillator.
// ----------------------------------------------------------------------------
package mwno_pkg;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [1:0] WAVE_SINE  = 2'd0;
    localparam logic [1:0] WAVE_SAW   = 2'd1;
    localparam logic [1:0] WAVE_TRI   = 2'd2;
    localparam logic [1:0] WAVE_PULSE = 2'd3;

    localparam logic [1:0] CFG_WAVEFORM          = 2'd0;
    localparam logic [1:0] CFG_BIT_DEPTH         = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_RATE       = 2'd2;
    localparam logic [1:0] CFG_SAMPLES_PER_COUNT = 2'd3;

    localparam logic [1:0] DIV_STEP = 2'd0;
    localparam logic [1:0] DIV_PER  = 2'd1;
    localparam logic [1:0] DIV_HI   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int WAVE_W     = 2;
    localparam int DEPTH_W    = 5;
    localparam int RATE_W     = 18;
    localparam int SPC_W      = 20;
    localparam int FREQ_W     = 23;
    localparam int COUNT_W    = 12;
    localparam int SAMPLE_W   = 24;
    localparam int LEN_W      = 18;
    localparam int PERIODS_W  = 24;
    localparam int BUDGET_W   = 32;
    localparam int DIVISOR_W  = 24;
    localparam int SINE_W     = 31;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] SINE_COEF [6] = '{64'd3864, 64'd172275, 64'd5026995,
                                              64'd85569306, 64'd693598668,
                                              64'd1686629713};

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_store;
        logic       fin;
        logic       pulse_emit;
        logic       wave_s1;
        logic       wave_s2;
        logic       wave_s3;
        logic       wave_emit;
    } t_cmd;

    typedef struct packed {
        logic load_pulse;
        logic pulse_act;
        logic wave_act;
        logic div_done;
        logic out_free;
    } t_status;

    // Odd polynomial for one quarter-wave table entry, x in Q30.
    function automatic logic [SINE_W-1:0] sine_poly(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] p;
        logic [63:0] s;
        int          t;
        y = (x * x) >> 30;
        p = SINE_COEF[0];
        for (t = 1; t < 6; t++) begin
            p = SINE_COEF[t] - ((y * p) >> 30);
        end
        s = (x * p) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return s[SINE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mwno_note_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwno_note_if
// Request channel of note loads and sample ticks.
// ----------------------------------------------------------------------------
interface mwno_note_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [mwno_pkg::FREQ_W-1:0]   note_frequency;
    logic [mwno_pkg::COUNT_W-1:0]  note_count;

    modport source (output valid, output func, output note_frequency,
                    output note_count, input ready);
    modport sink (input valid, input func, input note_frequency,
                  input note_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/mwno_sample_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwno_sample_if
// Result channel of signed samples with an end-of-note flag.
// ----------------------------------------------------------------------------
interface mwno_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [mwno_pkg::SAMPLE_W-1:0] sample_value;
    logic                                last_sample;

    modport source (output valid, output sample_value, output last_sample,
                    input ready);
    modport sink (input valid, input sample_value, input last_sample,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/mwno_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwno_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mwno_divider #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_fit;

    assign w_shift = {r_rem, r_num[NUM_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule
`default_nettype wire

// ----- rtl/mwno_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwno_datapath
// Configuration, note state, divider, waveform pipeline and output register.
// ----------------------------------------------------------------------------
module mwno_datapath #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mwno_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mwno_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [mwno_pkg::FREQ_W-1:0]        i_note_frequency,
    input  wire logic [mwno_pkg::COUNT_W-1:0]       i_note_count,
    input  wire mwno_pkg::t_cmd                     i_cmd,
    output mwno_pkg::t_status                       o_status,
    input  wire logic                               i_sample_ready,
    output logic                                    o_sample_valid,
    output logic signed [mwno_pkg::SAMPLE_W-1:0]    o_sample_value,
    output logic                                    o_last_sample
);
    localparam int NUM_W = PHASE_BITS + 15;
    localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IPW   = 30 + IW;
    localparam int SW    = mwno_pkg::SAMPLE_W;
    localparam int LW    = mwno_pkg::LEN_W;

    logic [mwno_pkg::WAVE_W-1:0]    r_waveform;
    logic [mwno_pkg::DEPTH_W-1:0]   r_bit_depth;
    logic [mwno_pkg::RATE_W-1:0]    r_sample_rate;
    logic [mwno_pkg::SPC_W-1:0]     r_spc;
    logic [mwno_pkg::FREQ_W-1:0]    r_f;
    logic [mwno_pkg::COUNT_W-1:0]   r_c;
    logic [mwno_pkg::RATE_W-1:0]    r_sr;
    logic                           r_load_pulse;
    logic [PHASE_BITS-1:0]          r_phase;
    logic [PHASE_BITS-1:0]          r_step;
    logic [mwno_pkg::BUDGET_W-1:0]  r_samples;
    logic [LW-1:0]                  r_plen;
    logic [LW-1:0]                  r_hlen;
    logic [LW-1:0]                  r_ppos;
    logic [mwno_pkg::PERIODS_W-1:0] r_periods;
    logic [31:0]                    r_u;
    logic [1:0]                     r_q;
    logic [IW-1:0]                  r_tidx;
    logic [mwno_pkg::SINE_W-1:0]    r_sine;
    logic [32:0]                    r_t;
    logic                           r_neg;
    logic [SW-1:0]                  r_mag;
    logic                           r_out_valid;
    logic [SW-1:0]                  r_out_value;
    logic                           r_out_last;

    logic [31:0]             w_u;
    logic [IPW-1:0]          w_idx_prod;
    logic [IW-1:0]           w_idx;
    logic [mwno_pkg::SINE_W-1:0] w_sine_tab [0:SINE_TABLE_DEPTH];
    logic [4:0]              w_b;
    logic [SW-1:0]           w_full;
    logic [SW-1:0]           w_half;
    logic [32:0]             w_u2;
    logic [32:0]             w_t;
    logic                    w_neg;
    logic [56:0]             w_prod_f;
    logic [54:0]             w_prod_s;
    logic [NUM_W-1:0]        w_num;
    logic [mwno_pkg::DIVISOR_W-1:0] w_den;
    logic                    w_div_done;
    logic [NUM_W-1:0]        w_quot;
    logic [LW-1:0]           w_len_sat;
    logic [34:0]             w_fc;
    logic [35:0]             w_fc_round;
    logic [31:0]             w_sc;
    logic [32:0]             w_sc_round;
    logic [LW:0]             w_ppos_next;
    logic                    w_out_free;

    // Quarter-wave sine table, built at elaboration.
    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
        if (k == 0) begin : g_zero
            assign w_sine_tab[k] = '0;
        end else if (k == SINE_TABLE_DEPTH) begin : g_one
            assign w_sine_tab[k] = mwno_pkg::Q30_ONE[mwno_pkg::SINE_W-1:0];
        end else begin : g_poly
            localparam logic [63:0] X = (64'(k) << 30) / SINE_TABLE_DEPTH;
            assign w_sine_tab[k] = mwno_pkg::sine_poly(X);
        end
    end

    if (PHASE_BITS >= 32) begin : g_u_hi
        assign w_u = r_phase[PHASE_BITS-1 -: 32];
    end else begin : g_u_lo
        assign w_u = {r_phase, {(32 - PHASE_BITS){1'b0}}};
    end

    assign w_idx_prod = IPW'(w_u[29:0]) * IPW'(SINE_TABLE_DEPTH);
    assign w_idx      = w_idx_prod[30 +: IW];

    assign w_b    = (r_bit_depth < 5'd8) ? 5'd8 : (r_bit_depth > 5'd24) ? 5'd24 : r_bit_depth;
    assign w_full = SW'((25'd1 << w_b) - 25'd1);
    assign w_half = SW'((25'd1 << (w_b - 5'd1)) - 25'd1);

    assign w_u2 = {r_u, 1'b0};
    always_comb begin
        w_t   = '0;
        w_neg = 1'b0;
        case (r_waveform)
            mwno_pkg::WAVE_SINE: begin
                w_neg = r_q[1];
            end
            mwno_pkg::WAVE_SAW: begin
                if (r_u[31]) begin
                    w_t   = 33'h1_0000_0000 - {1'b0, r_u};
                    w_neg = 1'b1;
                end else begin
                    w_t = {1'b0, r_u};
                end
            end
            mwno_pkg::WAVE_TRI: begin
                case (r_u[31:30])
                    2'd0: w_t = w_u2;
                    2'd1: w_t = 33'h1_0000_0000 - w_u2;
                    2'd2: w_t = w_u2 - 33'h1_0000_0000;
                    default: w_t = 33'd0 - w_u2;
                endcase
                w_neg = r_u[31];
            end
            default: begin
                w_t   = '0;
                w_neg = 1'b0;
            end
        endcase
    end

    assign w_prod_f = 57'(w_full) * 57'(r_t);
    assign w_prod_s = 55'(w_half) * 55'(r_sine);

    always_comb begin
        case (i_cmd.div_sel)
            mwno_pkg::DIV_PER: begin
                w_num = NUM_W'({r_sr, 8'd0}) + NUM_W'(r_f) - NUM_W'(1);
                w_den = mwno_pkg::DIVISOR_W'(r_f);
            end
            mwno_pkg::DIV_HI: begin
                w_num = NUM_W'({r_sr, 8'd0}) + NUM_W'(r_f);
                w_den = {r_f, 1'b0};
            end
            default: begin
                w_num = NUM_W'({r_f, {(PHASE_BITS - 8){1'b0}}})
                      + NUM_W'(r_sr[mwno_pkg::RATE_W-1:1]);
                w_den = mwno_pkg::DIVISOR_W'(r_sr);
            end
        endcase
    end

    mwno_divider #(
        .NUM_W (NUM_W),
        .DEN_W (mwno_pkg::DIVISOR_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_len_sat   = (w_quot > NUM_W'(mwno_pkg::LEN_MAX)) ? mwno_pkg::LEN_MAX
                                                             : w_quot[LW-1:0];
    assign w_fc        = 35'(r_f) * 35'(r_c);
    assign w_fc_round  = 36'(w_fc) + 36'd4095;
    assign w_sc        = 32'(r_spc) * 32'(r_c);
    assign w_sc_round  = 33'(w_sc) + 33'd15;
    assign w_ppos_next = (LW + 1)'(r_ppos) + (LW + 1)'(1);
    assign w_out_free  = !r_out_valid || i_sample_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform    <= mwno_pkg::WAVE_SINE;
            r_bit_depth   <= 5'd16;
            r_sample_rate <= 18'd44100;
            r_spc         <= 20'd22050;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mwno_pkg::CFG_WAVEFORM:    r_waveform    <= i_cfg_data[1:0];
                mwno_pkg::CFG_BIT_DEPTH:   r_bit_depth   <= i_cfg_data[4:0];
                mwno_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[17:0];
                default:                   r_spc         <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_step       <= '0;
            r_samples    <= '0;
            r_plen       <= '0;
            r_hlen       <= '0;
            r_ppos       <= '0;
            r_periods    <= '0;
            r_load_pulse <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_phase      <= '0;
                r_step       <= '0;
                r_samples    <= '0;
                r_plen       <= '0;
                r_hlen       <= '0;
                r_ppos       <= '0;
                r_periods    <= '0;
                r_load_pulse <= (r_waveform == mwno_pkg::WAVE_PULSE)
                             && (i_note_frequency != '0);
            end
            if (i_cmd.div_store) begin
                case (i_cmd.div_sel)
                    mwno_pkg::DIV_PER: r_plen <= w_len_sat;
                    mwno_pkg::DIV_HI:  r_hlen <= w_len_sat;
                    default:           r_step <= w_quot[PHASE_BITS-1:0];
                endcase
            end
            if (i_cmd.fin) begin
                if (r_load_pulse) begin
                    r_periods <= w_fc_round[12 +: mwno_pkg::PERIODS_W];
                end else begin
                    r_samples <= 32'(w_sc_round[32:4]);
                end
            end
            if (i_cmd.pulse_emit) begin
                if (w_ppos_next >= (LW + 1)'(r_plen)) begin
                    r_ppos    <= '0;
                    r_periods <= r_periods - mwno_pkg::PERIODS_W'(1);
                end else begin
                    r_ppos <= w_ppos_next[LW-1:0];
                end
            end
            if (i_cmd.wave_emit) begin
                r_phase   <= r_phase + r_step;
                r_samples <= r_samples - 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_f  <= i_note_frequency;
            r_c  <= i_note_count;
            r_sr <= (r_sample_rate == '0) ? 18'd1 : r_sample_rate;
        end
        if (i_cmd.wave_s1) begin
            r_u    <= w_u;
            r_q    <= w_u[31:30];
            r_tidx <= w_u[30] ? IW'(SINE_TABLE_DEPTH) - w_idx : w_idx;
        end
        if (i_cmd.wave_s2) begin
            r_sine <= w_sine_tab[r_tidx];
            r_t    <= w_t;
            r_neg  <= w_neg;
        end
        if (i_cmd.wave_s3) begin
            case (r_waveform)
                mwno_pkg::WAVE_SINE:  r_mag <= w_prod_s[30 +: SW];
                mwno_pkg::WAVE_PULSE: r_mag <= '0;
                default:              r_mag <= w_prod_f[32 +: SW];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pulse_emit || i_cmd.wave_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_sample_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pulse_emit) begin
            r_out_value <= (r_ppos < r_hlen) ? w_half : SW'(0) - w_half;
            r_out_last  <= (w_ppos_next >= (LW + 1)'(r_plen))
                        && (r_periods == mwno_pkg::PERIODS_W'(1));
        end else if (i_cmd.wave_emit) begin
            r_out_value <= r_neg ? SW'(0) - r_mag : r_mag;
            r_out_last  <= r_samples == 32'd1;
        end
    end

    assign o_status.load_pulse = r_load_pulse;
    assign o_status.pulse_act  = (r_plen != '0) && (r_periods != '0);
    assign o_status.wave_act   = r_samples != '0;
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = w_out_free;

    assign o_sample_valid = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_last_sample  = r_out_last;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pulse_emit || i_cmd.wave_emit) |-> w_out_free)
        else $error("sample emitted into a full output register");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_status.pulse_act && o_status.wave_act))
        else $error("pulse and waveform note active together");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pulse_emit || i_cmd.wave_emit) |=> r_out_valid)
        else $error("emitted sample not presented");
`endif
endmodule
`default_nettype wire

// ----- rtl/mwno_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwno_ctrl
// Sequencer for note loads and sample ticks.
// ----------------------------------------------------------------------------
module mwno_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_note_valid,
    input  wire logic              i_note_func,
    output logic                   o_note_ready,
    input  wire mwno_pkg::t_status i_status,
    output mwno_pkg::t_cmd         o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV1  = 4'd1;
    localparam logic [3:0] S_DIV1W = 4'd2;
    localparam logic [3:0] S_DIV2  = 4'd3;
    localparam logic [3:0] S_DIV2W = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_PEMIT = 4'd6;
    localparam logic [3:0] S_W1    = 4'd7;
    localparam logic [3:0] S_W2    = 4'd8;
    localparam logic [3:0] S_W3    = 4'd9;
    localparam logic [3:0] S_WEMIT = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_note_ready = r_state == S_IDLE;
    assign w_accept     = i_note_valid && o_note_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = mwno_pkg::DIV_STEP;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_note_func == mwno_pkg::FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV1;
                    end else if (i_status.pulse_act) begin
                        n_state = S_PEMIT;
                    end else if (i_status.wave_act) begin
                        n_state = S_W1;
                    end
                end
            end
            S_DIV1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = i_status.load_pulse ? mwno_pkg::DIV_PER : mwno_pkg::DIV_STEP;
                n_state         = S_DIV1W;
            end
            S_DIV1W: begin
                o_cmd.div_sel = i_status.load_pulse ? mwno_pkg::DIV_PER : mwno_pkg::DIV_STEP;
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state = i_status.load_pulse ? S_DIV2 : S_FIN;
                end
            end
            S_DIV2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = mwno_pkg::DIV_HI;
                n_state         = S_DIV2W;
            end
            S_DIV2W: begin
                o_cmd.div_sel = mwno_pkg::DIV_HI;
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            S_PEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.pulse_emit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_W1: begin
                o_cmd.wave_s1 = 1'b1;
                n_state       = S_W2;
            end
            S_W2: begin
                o_cmd.wave_s2 = 1'b1;
                n_state       = S_W3;
            end
            S_W3: begin
                o_cmd.wave_s3 = 1'b1;
                n_state       = S_WEMIT;
            end
            S_WEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.wave_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/multi_waveform_note_oscillator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_note_oscillator
// Single-voice tone generator: sine, sawtooth, triangle and pulse notes.
// ----------------------------------------------------------------------------
// Note load: the bit-serial divider computes the phase step, or for a pulse
// note the period and high lengths, one division after the other.
// Tick: index, table read, scaling and output for a waveform, output alone for a
// pulse sample, plus any wait while the output register is still full.
// Reset is synchronous and active low; configuration returns to its defaults.
module multi_waveform_note_oscillator #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mwno_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mwno_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mwno_note_if.sink                            i_note,
    mwno_sample_if.source                        o_sample
);
    mwno_pkg::t_cmd    w_cmd;
    mwno_pkg::t_status w_status;

    mwno_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_note_valid (i_note.valid),
        .i_note_func  (i_note.func),
        .o_note_ready (i_note.ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    mwno_datapath #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_note_frequency (i_note.note_frequency),
        .i_note_count     (i_note.note_count),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_sample_ready   (o_sample.ready),
        .o_sample_valid   (o_sample.valid),
        .o_sample_value   (o_sample.sample_value),
        .o_last_sample    (o_sample.last_sample)
    );
endmodule
`default_nettype wire

// ----- test/tb_mwno_checker.sv -----
// ----------------------------------------------------------------------------
// tb_mwno_checker
// Watches the note and sample channels and the register port of the
// oscillator, keeps its own copy of the note state, predicts every sample
// of the active note and compares each accepted sample with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_mwno_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [mwno_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [mwno_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    mwno_note_if                                      note,
    mwno_sample_if                                    sample,
    output int                                        o_errors,
    output int                                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [mwno_pkg::SAMPLE_W-1:0] value;
        logic                          last;
    } t_sample;

    logic [63:0]                    quarter_sine [0:256];
    logic [mwno_pkg::WAVE_W-1:0]    cur_wave;
    logic [mwno_pkg::DEPTH_W-1:0]   cur_depth;
    logic [mwno_pkg::RATE_W-1:0]    cur_rate;
    logic [mwno_pkg::SPC_W-1:0]     cur_spc;
    logic [31:0]                    phase;
    logic [31:0]                    step;
    logic [31:0]                    budget;
    logic [mwno_pkg::LEN_W-1:0]     per_len;
    logic [mwno_pkg::LEN_W-1:0]     high_len;
    logic [mwno_pkg::LEN_W-1:0]     per_pos;
    logic [mwno_pkg::PERIODS_W-1:0] per_left;
    t_sample                        expected_samples [$];
    int                             errors = 0;

    initial begin
        logic [63:0] x, y, p, s;
        for (int k = 0; k <= 256; k++) begin
            x = (64'(k) << 30) / 256;
            y = (x * x) >> 30;
            p = 64'd3864;
            p = 64'd172275 - ((y * p) >> 30);
            p = 64'd5026995 - ((y * p) >> 30);
            p = 64'd85569306 - ((y * p) >> 30);
            p = 64'd693598668 - ((y * p) >> 30);
            p = 64'd1686629713 - ((y * p) >> 30);
            s = (x * p) >> 30;
            quarter_sine[k] = (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
        end
        quarter_sine[0] = 0;
        quarter_sine[256] = 64'd1 << 30;
    end

    function automatic logic [63:0] eff_depth();
        if (cur_depth < 8) return 8;
        if (cur_depth > 24) return 24;
        return 64'(cur_depth);
    endfunction

    function automatic logic [mwno_pkg::SAMPLE_W-1:0] phase_sample();
        logic [63:0] b, half, full, u, mag, s, t;
        logic [7:0]  idx;
        logic        neg;
        b = eff_depth();
        half = (64'd1 << (b - 1)) - 1;
        full = (64'd1 << b) - 1;
        u = 64'(phase);
        mag = 0;
        neg = 1'b0;
        if (cur_wave == mwno_pkg::WAVE_SINE) begin
            idx = phase[29:22];
            s = phase[30] ? quarter_sine[256 - int'(idx)] : quarter_sine[idx];
            mag = (half * s) >> 30;
            neg = phase[31];
        end else if (cur_wave == mwno_pkg::WAVE_SAW) begin
            if (!phase[31]) begin
                mag = (full * u) >> 32;
            end else begin
                mag = (full * (64'h1_0000_0000 - u)) >> 32;
                neg = 1'b1;
            end
        end else if (cur_wave == mwno_pkg::WAVE_TRI) begin
            case (phase[31:30])
                2'd0: t = 2 * u;
                2'd1: t = 64'h1_0000_0000 - 2 * u;
                2'd2: t = 2 * u - 64'h1_0000_0000;
                default: t = 64'h2_0000_0000 - 2 * u;
            endcase
            neg = phase[31];
            mag = (full * t) >> 32;
        end
        return neg ? mwno_pkg::SAMPLE_W'(-mag) : mwno_pkg::SAMPLE_W'(mag);
    endfunction

    task automatic predict_request(input logic func, input logic [63:0] f,
                                   input logic [63:0] c);
        logic [63:0] sr, num, per, hi, peak;
        t_sample     r;
        sr = (cur_rate == 0) ? 64'd1 : 64'(cur_rate);
        if (func == mwno_pkg::FUNC_LOAD) begin
            phase = 0;
            per_pos = 0;
            if (cur_wave == mwno_pkg::WAVE_PULSE && f != 0) begin
                num = sr * 256;
                per = (num + f - 1) / f;
                hi = (num + f) / (2 * f);
                per_len = (per > 64'(mwno_pkg::LEN_MAX)) ? mwno_pkg::LEN_MAX
                                                         : mwno_pkg::LEN_W'(per);
                high_len = (hi > 64'(mwno_pkg::LEN_MAX)) ? mwno_pkg::LEN_MAX
                                                         : mwno_pkg::LEN_W'(hi);
                per_left = mwno_pkg::PERIODS_W'((f * c + 4095) >> 12);
                step = 0;
                budget = 0;
            end else begin
                step = 32'(((f << 24) + sr / 2) / sr);
                budget = 32'((64'(cur_spc) * c + 15) >> 4);
                per_len = 0;
                high_len = 0;
                per_left = 0;
            end
        end else if (per_len != 0 && per_left != 0) begin
            peak = (64'd1 << (eff_depth() - 1)) - 1;
            r.value = (per_pos < high_len) ? mwno_pkg::SAMPLE_W'(peak)
                                           : mwno_pkg::SAMPLE_W'(-peak);
            per_pos++;
            if (per_pos >= per_len) begin
                per_pos = 0;
                per_left--;
            end
            r.last = (per_left == 0);
            expected_samples.insert(expected_samples.size(), r);
        end else if (budget != 0) begin
            r.value = phase_sample();
            phase = phase + step;
            budget--;
            r.last = (budget == 0);
            expected_samples.insert(expected_samples.size(), r);
        end
    endtask

    always @(posedge i_clk) begin
        t_sample e;
        if (!i_rst_n) begin
            cur_wave = mwno_pkg::WAVE_SINE;
            cur_depth = 16;
            cur_rate = 44100;
            cur_spc = 22050;
            phase = 0;
            step = 0;
            budget = 0;
            per_len = 0;
            high_len = 0;
            per_pos = 0;
            per_left = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mwno_pkg::CFG_WAVEFORM:
                        cur_wave = i_cfg_data[mwno_pkg::WAVE_W-1:0];
                    mwno_pkg::CFG_BIT_DEPTH:
                        cur_depth = i_cfg_data[mwno_pkg::DEPTH_W-1:0];
                    mwno_pkg::CFG_SAMPLE_RATE:
                        cur_rate = i_cfg_data[mwno_pkg::RATE_W-1:0];
                    default:
                        cur_spc = i_cfg_data[mwno_pkg::SPC_W-1:0];
                endcase
            end
            if (sample.valid && sample.ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample %0d last %0b", $realtime,
                             $signed(sample.sample_value), sample.last_sample);
                    errors++;
                end else begin
                    e = expected_samples.pop_front();
                    if (sample.sample_value !== e.value ||
                        sample.last_sample !== e.last) begin
                        $display("%0t: expected sample %0d last %0b, got %0d last %0b",
                                 $realtime, $signed(e.value), e.last,
                                 $signed(sample.sample_value), sample.last_sample);
                        errors++;
                    end
                end
            end
            if (note.valid && note.ready) begin
                predict_request(note.func, 64'(note.note_frequency), 64'(note.note_count));
            end
        end
        o_errors <= errors;
        o_pending <= expected_samples.size();
    end
endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives note loads and ticks into the oscillator over a series of register
// settings and handshake pressures; the checker beside the block predicts
// and compares the samples, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_FREE = 0;
    localparam int MODE_SEND_IDLE = 1;
    localparam int MODE_RECV_STALL = 2;
    localparam int MODE_BOTH = 3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES = 13;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [mwno_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mwno_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                              mode = MODE_FREE;
    logic                            press_req = 1'b0;
    logic                            press_done = 1'b0;
    int                              stall_cnt = 0;
    int                              cycles = 0;
    int                              errors;
    int                              pending;

    mwno_note_if   note_ch ();
    mwno_sample_if sample_ch ();

    multi_waveform_note_oscillator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_note(note_ch), .o_sample(sample_ch)
    );

    tb_mwno_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .note(note_ch), .sample(sample_ch), .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        note_ch.valid = 1'b0;
        note_ch.func = mwno_pkg::FUNC_TICK;
        note_ch.note_frequency = '0;
        note_ch.note_count = '0;
        sample_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cnt != 0) begin
            sample_ch.ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else if (press_req && !press_done) begin
            sample_ch.ready <= 1'b0;
            stall_cnt <= 400;
            press_done <= 1'b1;
        end else if (mode == MODE_RECV_STALL) begin
            sample_ch.ready <= ($urandom_range(0, 99) >= 48);
        end else if (mode == MODE_BOTH) begin
            sample_ch.ready <= ($urandom_range(0, 99) >= 38);
        end else begin
            sample_ch.ready <= 1'b1;
        end
    end

    task automatic send_request(input logic func,
                                input logic [mwno_pkg::FREQ_W-1:0] f,
                                input logic [mwno_pkg::COUNT_W-1:0] c);
        int gap_pct;
        gap_pct = (mode == MODE_SEND_IDLE) ? 48 : (mode == MODE_BOTH) ? 38 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            note_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        note_ch.valid <= 1'b1;
        note_ch.func <= func;
        note_ch.note_frequency <= f;
        note_ch.note_count <= c;
        @(posedge i_clk);
        while (!note_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_request(mwno_pkg::FUNC_TICK, mwno_pkg::FREQ_W'($urandom),
                     mwno_pkg::COUNT_W'($urandom));
    endtask

    task automatic write_reg(input logic [mwno_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mwno_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic settle();
        note_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0]                  wave_tab [NUM_PHASES] = '{mwno_pkg::WAVE_SINE,
            mwno_pkg::WAVE_PULSE, mwno_pkg::WAVE_SAW, mwno_pkg::WAVE_TRI,
            mwno_pkg::WAVE_PULSE, mwno_pkg::WAVE_SINE, mwno_pkg::WAVE_SAW,
            mwno_pkg::WAVE_TRI, mwno_pkg::WAVE_PULSE, mwno_pkg::WAVE_SINE,
            mwno_pkg::WAVE_TRI, mwno_pkg::WAVE_SAW, mwno_pkg::WAVE_PULSE};
        int                          depth_tab [NUM_PHASES] = '{16, 8, 24, 31, 24, 0, 8,
            24, 16, 24, 8, 20, 12};
        int                          rate_tab [NUM_PHASES] = '{44100, 1000, 192000, 8000,
            192000, 0, 262143, 48000, 0, 192000, 1000, 22050, 3000};
        int                          spc_tab [NUM_PHASES] = '{4, 2, 16, 1, 1, 3, 0,
            1048575, 5, 8, 2, 7, 1};
        logic [mwno_pkg::FREQ_W-1:0]  f;
        logic [mwno_pkg::COUNT_W-1:0] c;
        int                          sent;
        int                          ticks;
        int                          sel;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(mwno_pkg::CFG_WAVEFORM, mwno_pkg::CFG_DATA_W'(wave_tab[ph]));
            write_reg(mwno_pkg::CFG_BIT_DEPTH, mwno_pkg::CFG_DATA_W'(depth_tab[ph]));
            write_reg(mwno_pkg::CFG_SAMPLE_RATE, mwno_pkg::CFG_DATA_W'(rate_tab[ph]));
            write_reg(mwno_pkg::CFG_SAMPLES_PER_COUNT, mwno_pkg::CFG_DATA_W'(spc_tab[ph]));
            cfg_we <= 1'b0;
            mode = ph % 4;

            if (ph == 0) begin
                send_tick();
                send_request(mwno_pkg::FUNC_LOAD, mwno_pkg::FREQ_W'(0),
                             mwno_pkg::COUNT_W'(3));
                send_tick();
                send_tick();
                send_request(mwno_pkg::FUNC_LOAD, mwno_pkg::FREQ_W'(5120000),
                             mwno_pkg::COUNT_W'(4095));
                repeat (4) send_tick();
                send_request(mwno_pkg::FUNC_LOAD, mwno_pkg::FREQ_W'(1),
                             mwno_pkg::COUNT_W'(1));
                repeat (2) send_tick();
                send_request(mwno_pkg::FUNC_LOAD, mwno_pkg::FREQ_W'(112640),
                             mwno_pkg::COUNT_W'(0));
                send_tick();
                send_request(mwno_pkg::FUNC_LOAD, 23'h7FFFFF, mwno_pkg::COUNT_W'(16));
                repeat (5) send_tick();
            end
            if (ph == NUM_PHASES - 1) begin
                press_req <= 1'b1;
            end

            sent = 0;
            while (sent < 120) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) f = '0;
                else if (sel < 3) f = mwno_pkg::FREQ_W'($urandom_range(0, 5120000));
                else if (sel == 3) f = mwno_pkg::FREQ_W'($urandom_range(1, 4096));
                else f = mwno_pkg::FREQ_W'(256 * $urandom_range(20, 20000));
                c = ($urandom_range(0, 3) == 0) ? mwno_pkg::COUNT_W'($urandom)
                                                : mwno_pkg::COUNT_W'($urandom_range(0, 48));
                send_request(mwno_pkg::FUNC_LOAD, f, c);
                ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                    : $urandom_range(0, 30);
                repeat (ticks) send_tick();
                sent += ticks + 1;
            end
            settle();
        end

        repeat (150) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
